@@ sv/prrts_pkg.sv @@
// ---------------------------------------------------------------------------
// prrts_pkg
// Types and codes shared by the task scheduler, its channels and submodules.
// ---------------------------------------------------------------------------
package prrts_pkg;

  // Operation codes of a command word
  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_START  = 3'd1,
    OP_DELAY  = 3'd2,
    OP_YIELD  = 3'd3,
    OP_DELETE = 3'd4,
    OP_TICK   = 3'd5
  } op_t;

  // Status codes of a result word
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_PRIO = 2'd2,
    STAT_IGNORED  = 2'd3
  } status_t;

  // Per-task state codes
  typedef enum logic [2:0] {
    TS_READY    = 3'd0,
    TS_RUNNING  = 3'd1,
    TS_SLEEPING = 3'd3,
    TS_DELETED  = 3'd4
  } tstate_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN1,
    S_FIN2
  } seq_state_t;

  // Command word
  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  priority_req;
    logic [15:0] sleep_len;
    logic [7:0]  task_index;
  } cmd_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  task_slot;
    logic        idle;
    logic [7:0]  woke_mask;
    logic [31:0] selected_runs;
    logic [31:0] tick_count;
  } rsp_word_t;

  // Task memory entry: state and sleep countdown
  typedef struct packed {
    tstate_t     state;
    logic [15:0] countdown;
  } entry_t;

  // Outcome of visiting one entry during a tick walk
  typedef struct packed {
    entry_t entry;
    logic   woke;
    logic   take;
  } visit_res_t;

endpackage

@@ sv/prrts_cmd_if.sv @@
// ---------------------------------------------------------------------------
// prrts_cmd_if
// Command channel of the task scheduler: valid/ready with a command word.
// ---------------------------------------------------------------------------
interface prrts_cmd_if;
  logic                  valid;
  logic                  ready;
  prrts_pkg::cmd_word_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/prrts_rsp_if.sv @@
// ---------------------------------------------------------------------------
// prrts_rsp_if
// Result channel of the task scheduler: valid/ready with a result word.
// ---------------------------------------------------------------------------
interface prrts_rsp_if;
  logic                  valid;
  logic                  ready;
  prrts_pkg::rsp_word_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/priority_round_robin_task_scheduler_unit.sv @@
// ---------------------------------------------------------------------------
// priority_round_robin_task_scheduler_unit
// Task scheduler over a memory-held task table: priority, then round-robin.
//
// One command word is taken at a time and yields one result word. Create,
// start, delay, yield, delete and ignored commands finish in the cycle they
// are accepted. A tick walks the N created tasks one entry per cycle through
// the task memories (read, update, write back), then reads and bumps the run
// count of the chosen task, a step that is skipped when no task is runnable.
// The walk over the single read port of the task memory sets its pace. A new
// command is accepted as soon as the block is idle, even while the last
// result word still waits, if that word is taken in the same cycle. Task
// table contents need no initialization after reset.
// ---------------------------------------------------------------------------
module priority_round_robin_task_scheduler_unit #(
  parameter int NUM_TASKS      = 8,
  parameter int NUM_PRIORITIES = 8
) (
  input  logic       clk,
  input  logic       rst,
  prrts_cmd_if.sink  cmd,
  prrts_rsp_if.source rsp
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int PW = $clog2(NUM_PRIORITIES);
  localparam int EW = $bits(prrts_pkg::entry_t);
  localparam int BW = PW + 32;

  // Control registers
  prrts_pkg::seq_state_t state, state_next;
  logic [CW-1:0]         tasks_in_use, tasks_in_use_next;
  logic [IW-1:0]         cur, cur_next;
  logic [31:0]           sys_time, sys_time_next;
  logic                  sched_on, sched_on_next;
  logic                  out_valid, out_valid_next;

  // Walk registers
  logic [IW-1:0]         rd_idx, rd_idx_next;
  logic [CW-1:0]         left, left_next;
  logic [IW-1:0]         best, best_next;
  logic [PW-1:0]         lead_prio, lead_prio_next;
  logic                  found, found_next;
  logic [7:0]            woke, woke_next;
  logic                  cur_run, cur_run_next;
  prrts_pkg::rsp_word_t  res, res_next;

  // Memory ports
  logic                  a_we, b_we;
  logic [IW-1:0]         a_waddr, a_raddr, b_waddr, b_raddr;
  logic [EW-1:0]         a_wdata, a_rdata;
  logic [BW-1:0]         b_wdata, b_rdata;

  logic                  accept;
  logic [CW-1:0]         cur_inc, rd_inc;
  logic [IW-1:0]         start_idx, rd_wrap;
  logic [31:0]           runs_inc;
  prrts_pkg::entry_t     wr_entry;
  prrts_pkg::visit_res_t vis;

  // State and countdown per task
  prrts_ram #(.WIDTH(EW), .DEPTH(NUM_TASKS)) u_state_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Priority and run count per task
  prrts_ram #(.WIDTH(BW), .DEPTH(NUM_TASKS)) u_run_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  prrts_visit #(.PRIO_W(PW)) u_visit (
    .entry     (prrts_pkg::entry_t'(a_rdata)),
    .prio      (b_rdata[BW-1:32]),
    .have_best (found),
    .lead_prio (lead_prio),
    .res       (vis)
  );

  assign accept      = cmd.valid && cmd.ready;
  assign cmd.ready   = (state == prrts_pkg::S_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid   = out_valid;
  assign rsp.payload = res;

  // Round-robin successors that wrap at the task count
  assign cur_inc   = CW'(cur) + CW'(1);
  assign start_idx = (cur_inc == tasks_in_use) ? '0 : cur_inc[IW-1:0];
  assign rd_inc    = CW'(rd_idx) + CW'(1);
  assign rd_wrap   = (rd_inc == tasks_in_use) ? '0 : rd_inc[IW-1:0];
  assign runs_inc  = b_rdata[31:0] + 32'd1;
  assign a_wdata   = wr_entry;

  // Sequencer: decode commands, walk the table on a tick, finish the switch
  always_comb begin
    state_next        = state;
    tasks_in_use_next = tasks_in_use;
    cur_next          = cur;
    sys_time_next     = sys_time;
    sched_on_next     = sched_on;
    out_valid_next    = out_valid && !rsp.ready;
    rd_idx_next       = rd_idx;
    left_next         = left;
    best_next         = best;
    lead_prio_next    = lead_prio;
    found_next        = found;
    woke_next         = woke;
    cur_run_next      = cur_run;
    res_next          = res;
    a_we              = 1'b0;
    a_waddr           = cur;
    a_raddr           = rd_idx;
    wr_entry          = '{state: prrts_pkg::TS_READY, countdown: '0};
    b_we              = 1'b0;
    b_waddr           = cur;
    b_raddr           = rd_idx;
    b_wdata           = '0;

    unique case (state)
      prrts_pkg::S_IDLE: begin
        if (accept) begin
          res_next            = '0;
          res_next.status     = prrts_pkg::STAT_OK;
          res_next.tick_count = sys_time;
          out_valid_next      = 1'b1;
          unique case (cmd.payload.operation)
            prrts_pkg::OP_CREATE: begin
              if (tasks_in_use == CW'(NUM_TASKS)) begin
                res_next.status = prrts_pkg::STAT_FULL;
              end else if (cmd.payload.priority_req >= 8'(NUM_PRIORITIES)) begin
                res_next.status = prrts_pkg::STAT_BAD_PRIO;
              end else begin
                a_we               = 1'b1;
                a_waddr            = tasks_in_use[IW-1:0];
                wr_entry           = '{state: prrts_pkg::TS_READY, countdown: '0};
                b_we               = 1'b1;
                b_waddr            = tasks_in_use[IW-1:0];
                b_wdata            = {cmd.payload.priority_req[PW-1:0], 32'd0};
                tasks_in_use_next  = tasks_in_use + CW'(1);
                res_next.task_slot = 3'(tasks_in_use);
              end
            end
            prrts_pkg::OP_START: begin
              sched_on_next = 1'b1;
            end
            prrts_pkg::OP_DELAY: begin
              if (!sched_on) begin
                res_next.status = prrts_pkg::STAT_IGNORED;
              end else begin
                a_we     = 1'b1;
                wr_entry = '{state: prrts_pkg::TS_SLEEPING,
                             countdown: cmd.payload.sleep_len};
              end
            end
            prrts_pkg::OP_YIELD: begin
              if (!sched_on) begin
                res_next.status = prrts_pkg::STAT_IGNORED;
              end else begin
                a_we     = 1'b1;
                wr_entry = '{state: prrts_pkg::TS_READY, countdown: '0};
              end
            end
            prrts_pkg::OP_DELETE: begin
              if (cmd.payload.task_index >= 8'(tasks_in_use)) begin
                res_next.status = prrts_pkg::STAT_IGNORED;
              end else begin
                a_we     = 1'b1;
                a_waddr  = cmd.payload.task_index[IW-1:0];
                wr_entry = '{state: prrts_pkg::TS_DELETED, countdown: '0};
              end
            end
            prrts_pkg::OP_TICK: begin
              if (!sched_on) begin
                res_next.status = prrts_pkg::STAT_IGNORED;
              end else begin
                sys_time_next       = sys_time + 32'd1;
                res_next.tick_count = sys_time + 32'd1;
                if (tasks_in_use == '0) begin
                  res_next.idle = 1'b1;
                end else begin
                  // Issue the first read and hold the result until the walk ends
                  out_valid_next = 1'b0;
                  a_raddr        = start_idx;
                  b_raddr        = start_idx;
                  rd_idx_next    = start_idx;
                  left_next      = tasks_in_use - CW'(1);
                  found_next     = 1'b0;
                  woke_next      = '0;
                  cur_run_next   = 1'b0;
                  state_next     = prrts_pkg::S_WALK;
                end
              end
            end
            default: begin
              res_next.status = prrts_pkg::STAT_IGNORED;
            end
          endcase
        end
      end

      prrts_pkg::S_WALK: begin
        // Write back the visited entry and track the best candidate
        a_we     = 1'b1;
        a_waddr  = rd_idx;
        wr_entry = vis.entry;
        if (vis.woke) begin
          woke_next = woke | (8'd1 << rd_idx);
        end
        if (vis.take) begin
          best_next      = rd_idx;
          lead_prio_next = b_rdata[BW-1:32];
          found_next     = 1'b1;
        end
        if (rd_idx == cur) begin
          cur_run_next = (vis.entry.state == prrts_pkg::TS_RUNNING);
        end
        if (left != '0) begin
          a_raddr     = rd_wrap;
          b_raddr     = rd_wrap;
          rd_idx_next = rd_wrap;
          left_next   = left - CW'(1);
        end else if (found_next) begin
          state_next = prrts_pkg::S_FIN1;
        end else begin
          res_next.idle      = 1'b1;
          res_next.woke_mask = woke_next;
          out_valid_next     = 1'b1;
          state_next         = prrts_pkg::S_IDLE;
        end
      end

      prrts_pkg::S_FIN1: begin
        // Fetch the run count; demote the old running task if it is switched out
        b_raddr = best;
        if (cur != best && cur_run) begin
          a_we     = 1'b1;
          a_waddr  = cur;
          wr_entry = '{state: prrts_pkg::TS_READY, countdown: '0};
        end
        state_next = prrts_pkg::S_FIN2;
      end

      prrts_pkg::S_FIN2: begin
        // Run the chosen task and bump its run count
        a_we                   = 1'b1;
        a_waddr                = best;
        wr_entry               = '{state: prrts_pkg::TS_RUNNING, countdown: '0};
        b_we                   = 1'b1;
        b_waddr                = best;
        b_wdata                = {b_rdata[BW-1:32], runs_inc};
        res_next.task_slot     = 3'(best);
        res_next.selected_runs = runs_inc;
        res_next.woke_mask     = woke;
        cur_next               = best;
        out_valid_next         = 1'b1;
        state_next             = prrts_pkg::S_IDLE;
      end

      default: begin
        state_next = prrts_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= prrts_pkg::S_IDLE;
      tasks_in_use <= '0;
      cur          <= '0;
      sys_time     <= '0;
      sched_on     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      tasks_in_use <= tasks_in_use_next;
      cur          <= cur_next;
      sys_time     <= sys_time_next;
      sched_on     <= sched_on_next;
      out_valid    <= out_valid_next;
    end
  end

  // Walk and result payload
  always_ff @(posedge clk) begin
    rd_idx    <= rd_idx_next;
    left      <= left_next;
    best      <= best_next;
    lead_prio <= lead_prio_next;
    found     <= found_next;
    woke      <= woke_next;
    cur_run   <= cur_run_next;
    res       <= res_next;
  end

endmodule

@@ sv/prrts_ram.sv @@
// ---------------------------------------------------------------------------
// prrts_ram
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module prrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/prrts_visit.sv @@
// ---------------------------------------------------------------------------
// prrts_visit
// Per-entry step of a tick: count down a sleeper, wake it at zero, and
// decide whether the entry beats the best candidate seen so far.
// ---------------------------------------------------------------------------
module prrts_visit #(
  parameter int PRIO_W = 3
) (
  input  prrts_pkg::entry_t     entry,
  input  logic [PRIO_W-1:0]     prio,
  input  logic                  have_best,
  input  logic [PRIO_W-1:0]     lead_prio,
  output prrts_pkg::visit_res_t res
);

  prrts_pkg::entry_t upd;
  logic              woke;
  logic              runnable;

  // Count down a sleeper; a countdown of zero never wakes
  always_comb begin
    upd  = entry;
    woke = 1'b0;
    if (entry.state == prrts_pkg::TS_SLEEPING && entry.countdown != 16'd0) begin
      upd.countdown = entry.countdown - 16'd1;
      if (entry.countdown == 16'd1) begin
        upd.state = prrts_pkg::TS_READY;
        woke      = 1'b1;
      end
    end
  end

  // Take the entry on a strictly better priority, so earlier ones win ties
  assign runnable = (upd.state == prrts_pkg::TS_READY) ||
                    (upd.state == prrts_pkg::TS_RUNNING);

  assign res.entry = upd;
  assign res.woke  = woke;
  assign res.take  = runnable && (!have_best || prio < lead_prio);

endmodule
